/* rtl/core/binary_cpt_count_table_assert.svh */
// ============================================================================
// binary_cpt_count_table_assert.svh
// Assertion macros used by the checker of the count table.
// ============================================================================
`ifndef BINARY_CPT_COUNT_TABLE_ASSERT_SVH
`define BINARY_CPT_COUNT_TABLE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define BCCT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define BCCT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/bcct_pkg.sv */
// ============================================================================
// bcct_pkg
// Types and constants shared by the binary node count table modules.
// ============================================================================
`default_nettype none

package bcct_pkg;

    // Field widths of the command, result and configuration words.
    localparam int MODE_W     = 3;
    localparam int IN_IDX_W   = 8;
    localparam int POS_W      = 3;
    localparam int NP_W       = 4;
    localparam int OUT_CNT_W  = 20;
    localparam int PROB_W     = 17;

    // Divider: one quotient bit per step.
    localparam int DIV_STEPS  = PROB_W;
    localparam int STEP_W     = 5;

    // Command queue between the front and the back.
    localparam int Q_DEPTH    = 4;
    localparam int Q_PTR_W    = 2;

    // Command mode codes.
    localparam logic [MODE_W-1:0] MODE_CLEAR       = 3'd0;
    localparam logic [MODE_W-1:0] MODE_COUNT       = 3'd1;
    localparam logic [MODE_W-1:0] MODE_FLIP_SELF   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_FLIP_PARENT = 3'd3;
    localparam logic [MODE_W-1:0] MODE_READ        = 3'd4;

    // Probability constants in Q1.16.
    localparam logic [PROB_W-1:0] PROB_HALF = 17'd32768;
    localparam logic [PROB_W-1:0] PROB_ONE  = 17'd65536;

    // Operation handed from the front to the back.
    typedef enum logic [2:0] {
        OP_CLEAR,
        OP_COUNT,
        OP_FLIP_SELF,
        OP_FLIP_PARENT,
        OP_REPORT
    } op_kind_t;

    typedef struct packed {
        op_kind_t              kind;
        logic [IN_IDX_W-1:0]   idx;
        logic [IN_IDX_W-1:0]   old_idx;
        logic                  node_value;
        logic                  direction;
    } op_t;

    // Queue fill status.
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // Back-end sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_UPDATE,
        ST_DIV_START,
        ST_DIVIDE,
        ST_EMIT
    } back_state_t;

endpackage

`default_nettype wire

/* rtl/core/bcct_if.sv */
// ============================================================================
// bcct_if
// Valid/ready channels of the count table: command, result, configuration.
// ============================================================================
`default_nettype none

// Command channel: one word per case or request.
interface bcct_in_if import bcct_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [MODE_W-1:0]   mode;
    logic                node_value;
    logic [IN_IDX_W-1:0] parent_bits;
    logic                direction;
    logic [POS_W-1:0]    changed_pos;
    logic                changed_is_parent;

    modport source (output valid, mode, node_value, parent_bits, direction,
                    changed_pos, changed_is_parent, input ready);
    modport sink   (input valid, mode, node_value, parent_bits, direction,
                    changed_pos, changed_is_parent, output ready);
endinterface

// Result channel: one word per reported entry.
interface bcct_out_if import bcct_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [IN_IDX_W-1:0]  entry_index;
    logic [OUT_CNT_W-1:0] count_one;
    logic [OUT_CNT_W-1:0] count_zero;
    logic [PROB_W-1:0]    prob_one;
    logic                 saturated;
    logic                 last;

    modport source (output valid, entry_index, count_one, count_zero, prob_one,
                    saturated, last, input ready);
    modport sink   (input valid, entry_index, count_one, count_zero, prob_one,
                    saturated, last, output ready);
endinterface

// Configuration write channel: the parent count register.
interface bcct_cfg_if import bcct_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [NP_W-1:0] num_parents;

    modport source (output valid, num_parents, input ready);
    modport sink   (input valid, num_parents, output ready);
endinterface

`default_nettype wire

/* rtl/core/binary_cpt_count_table.sv */
// ============================================================================
// binary_cpt_count_table
// Steps from an accepted word to its result: queue, dequeue, read, update,
// 17-step divider, result load; an empty entry skips the divide steps. A parent
// flip reports its old entry first, then reads, updates and reports the new one.
// The back handles one word at a time, held by the serial divider and by a stalled
// result; a clear produces no word. Commands queue four deep.
// Reset: counts read as zero (valid bits cleared at once), parent count 0.
// ============================================================================
`default_nettype none

module binary_cpt_count_table import bcct_pkg::*; #(
    parameter int MAX_PARENTS = 8,
    parameter int COUNT_WIDTH = 20
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    bcct_cfg_if.sink    cfg,
    bcct_in_if.sink     cmd,
    bcct_out_if.source  result
);

    q_status_t q_status;
    logic      push;
    op_t       push_op;
    logic      pop;
    op_t       head_op;

    // Front: index forming and classification.
    bcct_front #(
        .MAX_PARENTS (MAX_PARENTS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .cfg      (cfg),
        .q_status (q_status),
        .push     (push),
        .push_op  (push_op)
    );

    // Operation queue.
    bcct_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .pop     (pop),
        .head_op (head_op),
        .status  (q_status)
    );

    // Back: memory update, division and result word.
    bcct_back #(
        .MAX_PARENTS (MAX_PARENTS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head_op  (head_op),
        .q_status (q_status),
        .pop      (pop),
        .result   (result)
    );

endmodule

`default_nettype wire

/* rtl/core/bcct_front.sv */
// ============================================================================
// bcct_front
// Accepts command words, forms table indexes and classifies each command.
// ============================================================================
`default_nettype none

module bcct_front import bcct_pkg::*; #(
    parameter int MAX_PARENTS = 8
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    bcct_in_if.sink      cmd,
    bcct_cfg_if.sink     cfg,
    input  q_status_t    q_status,
    output logic         push,
    output op_t          push_op
);

    localparam int IDX_W = (MAX_PARENTS < IN_IDX_W) ? MAX_PARENTS : IN_IDX_W;
    localparam logic [NP_W-1:0] NP_CAP = NP_W'(IDX_W);

    logic [NP_W-1:0]     num_parents_reg;
    logic [NP_W-1:0]     np_eff;
    logic [IN_IDX_W-1:0] idx_mask;
    logic [IN_IDX_W-1:0] tbl_mask;
    logic [IN_IDX_W-1:0] cur_idx;
    logic [IN_IDX_W-1:0] old_idx;
    logic                real_flip;
    logic                keep;

    // Parent count register; writes are always taken.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_parents_reg <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            num_parents_reg <= cfg.num_parents;
        end
    end

    // A parent count above the table size acts as the table size.
    assign np_eff = (num_parents_reg > NP_CAP) ? NP_CAP : num_parents_reg;

    // Index masks: configured parents and the full table.
    always_comb
    begin
        for (int b = 0; b < IN_IDX_W; b++)
        begin
            idx_mask[b] = (NP_W'(b) < np_eff);
            tbl_mask[b] = (b < IDX_W);
        end
    end

    assign cur_idx   = cmd.parent_bits & idx_mask;
    assign old_idx   = cur_idx ^ (IN_IDX_W'(1) << cmd.changed_pos);
    assign real_flip = cmd.changed_is_parent && ({1'b0, cmd.changed_pos} < np_eff);

    // The front stalls only when the queue is full.
    assign cmd.ready = !q_status.full;

    // Classify the command; unused modes are taken and dropped.
    always_comb
    begin
        keep               = 1'b1;
        push_op.kind       = OP_REPORT;
        push_op.idx        = cur_idx;
        push_op.old_idx    = old_idx;
        push_op.node_value = cmd.node_value;
        push_op.direction  = cmd.direction;
        case (cmd.mode)
            MODE_CLEAR:       push_op.kind = OP_CLEAR;
            MODE_COUNT:       push_op.kind = OP_COUNT;
            MODE_FLIP_SELF:   push_op.kind = OP_FLIP_SELF;
            MODE_FLIP_PARENT: push_op.kind = real_flip ? OP_FLIP_PARENT : OP_REPORT;
            MODE_READ:
            begin
                push_op.kind = OP_REPORT;
                push_op.idx  = cmd.parent_bits & tbl_mask;
            end
            default:          keep = 1'b0;
        endcase
    end

    assign push = cmd.valid && cmd.ready && keep;

endmodule

`default_nettype wire

/* rtl/core/bcct_queue.sv */
// ============================================================================
// bcct_queue
// Short FIFO of classified operations between the front and the back.
// ============================================================================
`default_nettype none

module bcct_queue import bcct_pkg::*; (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  wire op_t        push_op,
    input  wire logic       pop,
    output op_t             head_op,
    output q_status_t       status
);

    op_t                entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_PTR_W:0]   count_reg;

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    assign head_op      = entry_reg[rd_ptr_reg];
    assign status.full  = (count_reg == (Q_PTR_W + 1)'(Q_DEPTH));
    assign status.empty = (count_reg == '0);

endmodule

`default_nettype wire

/* rtl/core/bcct_div.sv */
// ============================================================================
// bcct_div
// Restoring divider for P(node=1) = (c1 << 16) / (c1 + c0), one bit a cycle.
// ============================================================================
`default_nettype none

module bcct_div import bcct_pkg::*; #(
    parameter int COUNT_WIDTH = 20
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire logic [COUNT_WIDTH-1:0] c1,
    input  wire logic [COUNT_WIDTH-1:0] c0,
    output logic                        done,
    output logic [PROB_W-1:0]           quotient
);

    localparam int TOT_W = COUNT_WIDTH + 1;
    localparam int REM_W = COUNT_WIDTH + 2;

    logic [TOT_W-1:0]  tot;
    logic [TOT_W-1:0]  den_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [PROB_W-1:0] quo_reg;
    logic              first_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [REM_W-1:0]  shifted;
    logic [REM_W-1:0]  diff;
    logic              take;

    assign tot = {1'b0, c1} + {1'b0, c0};

    // The first step uses c1 as it stands, since c1 never exceeds the total.
    assign shifted = first_reg ? rem_reg : {rem_reg[REM_W-2:0], 1'b0};
    assign take    = (shifted >= REM_W'(den_reg));
    assign diff    = shifted - REM_W'(den_reg);

    // Step control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            first_reg <= 1'b0;
            step_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg  <= (tot != '0);
            done_reg  <= (tot == '0);
            first_reg <= 1'b1;
            step_reg  <= STEP_W'(DIV_STEPS);
        end
        else if (busy_reg)
        begin
            first_reg <= 1'b0;
            step_reg  <= step_reg - 1'b1;
            if (step_reg == STEP_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Remainder and quotient; an empty entry gives one half.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            den_reg <= tot;
            rem_reg <= REM_W'(c1);
            quo_reg <= (tot == '0) ? PROB_HALF : '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= take ? diff : shifted;
            quo_reg <= {quo_reg[PROB_W-2:0], take};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

/* rtl/core/bcct_back.sv */
// ============================================================================
// bcct_back
// Executes queued operations on the count memory and reports each entry.
// ============================================================================
`default_nettype none

module bcct_back import bcct_pkg::*; #(
    parameter int MAX_PARENTS = 8,
    parameter int COUNT_WIDTH = 20
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire op_t        head_op,
    input  wire q_status_t  q_status,
    output logic            pop,
    bcct_out_if.source      result
);

    localparam int IDX_W = (MAX_PARENTS < IN_IDX_W) ? MAX_PARENTS : IN_IDX_W;
    localparam int DEPTH = 1 << IDX_W;
    localparam int CW    = COUNT_WIDTH;
    localparam int EXT_W = (CW > OUT_CNT_W) ? CW : OUT_CNT_W;
    localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};

    back_state_t          state_reg;
    back_state_t          state_next;
    op_t                  op_reg;
    logic                 phase_reg;
    logic [IDX_W-1:0]     addr_reg;
    logic [2*CW-1:0]      mem [DEPTH];
    logic [DEPTH-1:0]     valid_reg;
    logic [2*CW-1:0]      rd_data_reg;
    logic                 rd_valid_reg;
    logic [CW-1:0]        res_c1_reg;
    logic [CW-1:0]        res_c0_reg;
    logic                 res_sat_reg;

    logic                 out_valid_reg;
    logic [IN_IDX_W-1:0]  out_index_reg;
    logic [OUT_CNT_W-1:0] out_c1_reg;
    logic [OUT_CNT_W-1:0] out_c0_reg;
    logic [PROB_W-1:0]    out_prob_reg;
    logic                 out_sat_reg;
    logic                 out_last_reg;

    logic                 clear_all;
    logic                 mem_rd;
    logic                 mem_wr;
    logic                 do_update;
    logic                 div_start;
    logic                 out_load;
    logic                 second_entry;
    logic                 div_done;
    logic [PROB_W-1:0]    div_quo;

    logic [CW-1:0]        c1_cur;
    logic [CW-1:0]        c0_cur;
    logic                 inc1;
    logic                 inc0;
    logic                 dec1;
    logic                 dec0;
    logic [CW-1:0]        c1_new;
    logic [CW-1:0]        c0_new;
    logic                 sat_new;
    logic [EXT_W-1:0]     c1_ext;
    logic [EXT_W-1:0]     c0_ext;

    // A flip of a parent reports the old entry first, then the new one.
    assign second_entry = (op_reg.kind == OP_FLIP_PARENT) && !phase_reg;

    // Sequencer outputs.
    always_comb
    begin
        pop       = (state_reg == ST_IDLE) && !q_status.empty;
        clear_all = pop && (head_op.kind == OP_CLEAR);
        mem_rd    = (state_reg == ST_READ);
        do_update = (state_reg == ST_UPDATE);
        mem_wr    = do_update && (op_reg.kind != OP_REPORT);
        div_start = (state_reg == ST_DIV_START);
        out_load  = (state_reg == ST_EMIT) && (!out_valid_reg || result.ready);
    end

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_status.empty && (head_op.kind != OP_CLEAR))
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:      state_next = ST_UPDATE;
            ST_UPDATE:    state_next = ST_DIV_START;
            ST_DIV_START: state_next = ST_DIVIDE;
            ST_DIVIDE:
            begin
                if (div_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_load)
                begin
                    state_next = second_entry ? ST_READ : ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= 1'b0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (pop)
            begin
                phase_reg <= 1'b0;
            end
            else if (out_load)
            begin
                phase_reg <= 1'b1;
            end
            if (clear_all)
            begin
                valid_reg <= '0;
            end
            else if (mem_wr)
            begin
                valid_reg[addr_reg] <= 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Operation and address registers.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            op_reg   <= head_op;
            addr_reg <= (head_op.kind == OP_FLIP_PARENT) ? head_op.old_idx[IDX_W-1:0]
                                                        : head_op.idx[IDX_W-1:0];
        end
        else if (out_load && second_entry)
        begin
            addr_reg <= op_reg.idx[IDX_W-1:0];
        end
    end

    // Count memory: one write and one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_wr)
        begin
            mem[addr_reg] <= {c1_new, c0_new};
        end
        if (mem_rd)
        begin
            rd_data_reg  <= mem[addr_reg];
            rd_valid_reg <= valid_reg[addr_reg];
        end
    end

    // Entries not written since the last clear read as zero.
    assign c1_cur = rd_valid_reg ? rd_data_reg[2*CW-1:CW] : '0;
    assign c0_cur = rd_valid_reg ? rd_data_reg[CW-1:0]    : '0;

    // Which counters move for this operation.
    always_comb
    begin
        inc1 = 1'b0;
        inc0 = 1'b0;
        dec1 = 1'b0;
        dec0 = 1'b0;
        case (op_reg.kind)
            OP_COUNT:
            begin
                inc1 = op_reg.node_value;
                inc0 = !op_reg.node_value;
            end
            OP_FLIP_SELF:
            begin
                inc1 = op_reg.direction;
                dec0 = op_reg.direction;
                inc0 = !op_reg.direction;
                dec1 = !op_reg.direction;
            end
            OP_FLIP_PARENT:
            begin
                dec1 = !phase_reg && op_reg.node_value;
                dec0 = !phase_reg && !op_reg.node_value;
                inc1 = phase_reg && op_reg.node_value;
                inc0 = phase_reg && !op_reg.node_value;
            end
            default:
            begin
                inc1 = 1'b0;
            end
        endcase
    end

    // Saturating counter updates.
    always_comb
    begin
        c1_new = c1_cur;
        c0_new = c0_cur;
        if (inc1 && (c1_cur != CNT_MAX))
        begin
            c1_new = c1_cur + 1'b1;
        end
        else if (dec1 && (c1_cur != '0))
        begin
            c1_new = c1_cur - 1'b1;
        end
        if (inc0 && (c0_cur != CNT_MAX))
        begin
            c0_new = c0_cur + 1'b1;
        end
        else if (dec0 && (c0_cur != '0))
        begin
            c0_new = c0_cur - 1'b1;
        end
        sat_new = (inc1 && (c1_cur == CNT_MAX)) || (dec1 && (c1_cur == '0)) ||
                  (inc0 && (c0_cur == CNT_MAX)) || (dec0 && (c0_cur == '0));
    end

    // Updated counts held for the divider and the result word.
    always_ff @(posedge clk)
    begin
        if (do_update)
        begin
            res_c1_reg  <= c1_new;
            res_c0_reg  <= c0_new;
            res_sat_reg <= sat_new;
        end
    end

    bcct_div #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .c1       (res_c1_reg),
        .c0       (res_c0_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Result register.
    assign c1_ext = EXT_W'(res_c1_reg);
    assign c0_ext = EXT_W'(res_c0_reg);

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_index_reg <= IN_IDX_W'(addr_reg);
            out_c1_reg    <= c1_ext[OUT_CNT_W-1:0];
            out_c0_reg    <= c0_ext[OUT_CNT_W-1:0];
            out_prob_reg  <= div_quo;
            out_sat_reg   <= res_sat_reg;
            out_last_reg  <= !second_entry;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.entry_index = out_index_reg;
    assign result.count_one   = out_c1_reg;
    assign result.count_zero  = out_c0_reg;
    assign result.prob_one    = out_prob_reg;
    assign result.saturated   = out_sat_reg;
    assign result.last        = out_last_reg;

endmodule

`default_nettype wire

/* rtl/core/bcct_checker.sv */
// ============================================================================
// bcct_checker
// Port-level checks on the result channel of the count table.
// ============================================================================
`default_nettype none

`include "binary_cpt_count_table_assert.svh"

module bcct_checker import bcct_pkg::*; (
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 valid,
    input wire logic                 ready,
    input wire logic [IN_IDX_W-1:0]  entry_index,
    input wire logic [OUT_CNT_W-1:0] count_one,
    input wire logic [OUT_CNT_W-1:0] count_zero,
    input wire logic [PROB_W-1:0]    prob_one
);

    // The estimate never exceeds one.
    `BCCT_ASSERT_NOW(a_prob_range, valid, prob_one <= PROB_ONE, "prob_one above one")

    // An empty entry reports one half.
    `BCCT_ASSERT_NOW(a_empty_half, valid && (count_one == '0) && (count_zero == '0), prob_one == PROB_HALF, "empty entry not one half")

    // An entry with only zero cases reports zero.
    `BCCT_ASSERT_NOW(a_zero_only, valid && (count_one == '0) && (count_zero != '0), prob_one == '0, "zero-only entry not zero")

    // A stalled result word holds.
    `BCCT_ASSERT_NEXT(a_hold, valid && !ready, valid && $stable(entry_index) && $stable(prob_one), "stalled result changed")

endmodule

bind binary_cpt_count_table bcct_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .valid       (result.valid),
    .ready       (result.ready),
    .entry_index (result.entry_index),
    .count_one   (result.count_one),
    .count_zero  (result.count_zero),
    .prob_one    (result.prob_one)
);

`default_nettype wire
